FILE: rtl/core/tlsa_pkg.sv
// ----------------------------------------------------------------------------
// tlsa_pkg
// Shared widths, constants and types of the triangle light/shadow alpha unit.
// ----------------------------------------------------------------------------
package tlsa_pkg;

    // Field widths
    localparam int COORD_W   = 20;  // signed Q12.8 coordinate
    localparam int NORM_W    = 16;  // signed Q1.14 normal component
    localparam int VEC_W     = 3 * COORD_W;
    localparam int RNG_W     = 20;
    localparam int ENG_W     = 16;
    localparam int ALPHA_W   = 12;

    // Configuration port
    localparam int CFG_W     = VEC_W;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LVEC   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG    = 3'd5;

    // Internal widths
    localparam int DIF_W   = COORD_W + 1;       // coordinate difference
    localparam int ABS_W   = COORD_W;           // magnitude of a difference
    localparam int SQ_W    = 2 * ABS_W;
    localparam int D2_W    = SQ_W + 2;          // sum of three squares
    localparam int ROOT_W  = D2_W / 2;
    localparam int TERM_W  = DIF_W + NORM_W;
    localparam int DOT_W   = TERM_W + 2;
    localparam int NUM_W   = ENG_W + ROOT_W;
    localparam int DEN_W   = ROOT_W + 1;
    localparam int Q_W     = ENG_W;
    localparam int FADE_W  = 17;                // 0 .. 65536
    localparam int F12_W   = 2 * FADE_W - 1;    // 0 .. 2^32
    localparam int P_W     = ENG_W + F12_W;
    localparam int K_W     = 11;

    // Fade thresholds (squared distances in units of 2^-16)
    localparam logic [D2_W-1:0] CAM_T = 42'd150994944;  // 48^2
    localparam logic [D2_W-1:0] ORG_T = 42'd1327104;    // 4.5^2
    localparam int CAM_X_W = 28;
    localparam int ORG_X_W = 21;
    // Camera fade: floor((x >> 8) / 9) through a reciprocal
    localparam int CAM_Y_W = CAM_X_W - 8;
    localparam int CAM_M_W = 20;
    localparam logic [CAM_M_W-1:0] CAM_M = 20'd932068;
    localparam int CAM_SH  = 23;
    // Origin fade: floor(4x / 81) through a reciprocal
    localparam int ORG_Z_W = ORG_X_W + 2;
    localparam int ORG_M_W = 24;
    localparam logic [ORG_M_W-1:0] ORG_M = 24'd13256072;
    localparam int ORG_SH  = 30;

    localparam int ALPHA_GAIN_W = 10;
    localparam logic [ALPHA_GAIN_W-1:0] ALPHA_GAIN = 10'd765;  // 255 * 1.5 * 2
    localparam int ALPHA_SH = 47;
    localparam logic signed [ALPHA_W-1:0] ALPHA_MAX = 12'sd255;

    // Pipeline shape
    localparam int SQ_PER_STAGE  = 3;
    localparam int SQ_ITERS      = D2_W / 2;
    localparam int SQ_STAGES     = (SQ_ITERS + SQ_PER_STAGE - 1) / SQ_PER_STAGE;
    localparam int DIV_PER_STAGE = 4;
    localparam int DIV_STAGES    = (Q_W + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
    localparam int ACT_DLY       = SQ_STAGES + 1 + DIV_STAGES;
    localparam int F12_DLY       = ACT_DLY - 3;
    localparam int LATENCY       = 3 + SQ_STAGES + 1 + DIV_STAGES + 2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [NORM_W-1:0]  t_norm;

    typedef struct packed {
        logic               dir;
        logic [VEC_W-1:0]   lvec;
        logic [RNG_W-1:0]   rng;
        logic [ENG_W-1:0]   energy;
        logic [VEC_W-1:0]   cam;
        logic [VEC_W-1:0]   org;
    } t_cfg;

endpackage

FILE: rtl/core/tlsa_isqrt_pipe.sv
// ----------------------------------------------------------------------------
// tlsa_isqrt_pipe
// Pipelined integer square root, a few digit steps per register stage.
// ----------------------------------------------------------------------------
module tlsa_isqrt_pipe import tlsa_pkg::*; (
    input  logic              i_clk,
    input  logic [D2_W-1:0]   i_rad,
    output logic [ROOT_W-1:0] o_root
);

    logic [D2_W-1:0] r_x   [SQ_STAGES];
    logic [D2_W:0]   r_res [SQ_STAGES];

    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_st
        logic [D2_W-1:0] x_in;
        logic [D2_W:0]   res_in;
        logic [D2_W-1:0] n_x;
        logic [D2_W:0]   n_res;

        if (s == 0) begin : g_first
            assign x_in   = i_rad;
            assign res_in = '0;
        end else begin : g_next
            assign x_in   = r_x[s-1];
            assign res_in = r_res[s-1];
        end

        // Resolve the next root digits of this stage
        always_comb begin
            logic [D2_W:0] bitv;
            logic [D2_W:0] trial;
            n_x   = x_in;
            n_res = res_in;
            bitv  = '0;
            trial = '0;
            for (int k = 0; k < SQ_PER_STAGE; k++) begin
                if (s * SQ_PER_STAGE + k < SQ_ITERS) begin
                    bitv  = (D2_W+1)'(1) << (D2_W - 2 - 2 * (s * SQ_PER_STAGE + k));
                    trial = n_res + bitv;
                    if ({1'b0, n_x} >= trial) begin
                        n_x   = n_x - trial[D2_W-1:0];
                        n_res = (n_res >> 1) + bitv;
                    end else begin
                        n_res = n_res >> 1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[s]   <= n_x;
            r_res[s] <= n_res;
        end
    end

    assign o_root = r_res[SQ_STAGES-1][ROOT_W-1:0];

endmodule

FILE: rtl/core/tlsa_div_pipe.sv
// ----------------------------------------------------------------------------
// tlsa_div_pipe
// Pipelined restoring divider, a few quotient bits per register stage.
// The quotient must fit in Q_W bits.
// ----------------------------------------------------------------------------
module tlsa_div_pipe import tlsa_pkg::*; (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);

    logic [NUM_W-1:0] r_rem [DIV_STAGES];
    logic [DEN_W-1:0] r_den [DIV_STAGES];
    logic [Q_W-1:0]   r_quo [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   quo_in;
        logic [NUM_W-1:0] n_rem;
        logic [Q_W-1:0]   n_quo;

        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        // Subtract the shifted divisor where it fits
        always_comb begin
            logic [NUM_W-1:0] shifted;
            n_rem   = rem_in;
            n_quo   = quo_in;
            shifted = '0;
            for (int k = 0; k < DIV_PER_STAGE; k++) begin
                if (s * DIV_PER_STAGE + k < Q_W) begin
                    shifted = NUM_W'(den_in) << (Q_W - 1 - (s * DIV_PER_STAGE + k));
                    if (n_rem >= shifted) begin
                        n_rem = n_rem - shifted;
                        n_quo = n_quo | (Q_W'(1) << (Q_W - 1 - (s * DIV_PER_STAGE + k)));
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_den[s] <= den_in;
            r_quo[s] <= n_quo;
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

FILE: rtl/core/tlsa_vertex_lane.sv
// ----------------------------------------------------------------------------
// tlsa_vertex_lane
// Alpha of one vertex: distances, facing test, fades, light falloff and
// final scaling, one register stage after each step.
// ----------------------------------------------------------------------------
module tlsa_vertex_lane import tlsa_pkg::*; (
    input  logic                      i_clk,
    input  t_cfg                      i_cfg,
    input  t_coord                    i_px,
    input  t_coord                    i_py,
    input  t_coord                    i_pz,
    input  t_norm                     i_nx,
    input  t_norm                     i_ny,
    input  t_norm                     i_nz,
    output logic signed [ALPHA_W-1:0] o_alpha
);

    t_coord p   [3];
    t_norm  nrm [3];
    t_coord lv  [3];
    t_coord cam [3];
    t_coord org [3];

    assign p[0] = i_px;
    assign p[1] = i_py;
    assign p[2] = i_pz;
    assign nrm[0] = i_nx;
    assign nrm[1] = i_ny;
    assign nrm[2] = i_nz;

    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign lv[i]  = i_cfg.lvec[COORD_W*i +: COORD_W];
        assign cam[i] = i_cfg.cam[COORD_W*i +: COORD_W];
        assign org[i] = i_cfg.org[COORD_W*i +: COORD_W];
    end

    // Stage 1: differences and facing operands
    logic        [ABS_W-1:0]  r_s1_dl [3];
    logic        [ABS_W-1:0]  r_s1_dc [3];
    logic        [ABS_W-1:0]  r_s1_do [3];
    logic signed [DIF_W-1:0]  r_s1_ad [3];
    t_norm                    r_s1_n  [3];
    logic        [2*RNG_W-1:0] r_s1_rng2;

    for (genvar i = 0; i < 3; i++) begin : g_s1
        logic signed [DIF_W-1:0] dl, dc, dq;
        assign dl = DIF_W'(p[i]) - DIF_W'(lv[i]);
        assign dc = DIF_W'(p[i]) - DIF_W'(cam[i]);
        assign dq = DIF_W'(p[i]) - DIF_W'(org[i]);
        always_ff @(posedge i_clk) begin
            r_s1_dl[i] <= ABS_W'(dl < 0 ? -dl : dl);
            r_s1_dc[i] <= ABS_W'(dc < 0 ? -dc : dc);
            r_s1_do[i] <= ABS_W'(dq < 0 ? -dq : dq);
            r_s1_ad[i] <= i_cfg.dir ? -DIF_W'(lv[i]) : -dl;
            r_s1_n[i]  <= nrm[i];
        end
    end

    // Range squared follows the static range register
    always_ff @(posedge i_clk) begin
        r_s1_rng2 <= (2*RNG_W)'(i_cfg.rng) * (2*RNG_W)'(i_cfg.rng);
    end

    // Stage 2: squares and dot product terms
    logic        [SQ_W-1:0]   r_s2_sl [3];
    logic        [SQ_W-1:0]   r_s2_sc [3];
    logic        [SQ_W-1:0]   r_s2_so [3];
    logic signed [TERM_W-1:0] r_s2_t  [3];

    for (genvar i = 0; i < 3; i++) begin : g_s2
        always_ff @(posedge i_clk) begin
            r_s2_sl[i] <= SQ_W'(r_s1_dl[i]) * SQ_W'(r_s1_dl[i]);
            r_s2_sc[i] <= SQ_W'(r_s1_dc[i]) * SQ_W'(r_s1_dc[i]);
            r_s2_so[i] <= SQ_W'(r_s1_do[i]) * SQ_W'(r_s1_do[i]);
            r_s2_t[i]  <= TERM_W'(r_s1_ad[i]) * TERM_W'(r_s1_n[i]);
        end
    end

    // Stage 3: sums, facing and range test
    logic [D2_W-1:0] r_s3_d2l;
    logic [D2_W-1:0] r_s3_d2c;
    logic [D2_W-1:0] r_s3_d2o;
    logic            r_s3_act;
    logic [D2_W-1:0]         d2l;
    logic signed [DOT_W-1:0] dot;

    assign d2l = D2_W'(r_s2_sl[0]) + D2_W'(r_s2_sl[1]) + D2_W'(r_s2_sl[2]);
    assign dot = DOT_W'(r_s2_t[0]) + DOT_W'(r_s2_t[1]) + DOT_W'(r_s2_t[2]);

    always_ff @(posedge i_clk) begin
        r_s3_d2l <= d2l;
        r_s3_d2c <= D2_W'(r_s2_sc[0]) + D2_W'(r_s2_sc[1]) + D2_W'(r_s2_sc[2]);
        r_s3_d2o <= D2_W'(r_s2_so[0]) + D2_W'(r_s2_so[1]) + D2_W'(r_s2_so[2]);
        r_s3_act <= (dot > 0) && (i_cfg.dir || d2l <= D2_W'(r_s1_rng2));
    end

    // Stage 4: fade numerators, clamped at the threshold
    logic [CAM_Y_W-1:0] r_s4_yc;
    logic [ORG_Z_W-1:0] r_s4_zo;
    logic [D2_W-1:0]    xc_full, xo_full;

    assign xc_full = (r_s3_d2c >= CAM_T) ? '0 : CAM_T - r_s3_d2c;
    assign xo_full = (r_s3_d2o >= ORG_T) ? '0 : ORG_T - r_s3_d2o;

    always_ff @(posedge i_clk) begin
        r_s4_yc <= xc_full[CAM_X_W-1:8];
        r_s4_zo <= {xo_full[ORG_X_W-1:0], 2'b00};
    end

    // Stage 5: divide by the fade constants through reciprocals
    logic [FADE_W-1:0] r_s5_f1;
    logic [FADE_W-1:0] r_s5_f2;
    logic [CAM_Y_W+CAM_M_W-1:0] mc;
    logic [ORG_Z_W+ORG_M_W-1:0] mo;

    assign mc = (CAM_Y_W+CAM_M_W)'(r_s4_yc) * (CAM_Y_W+CAM_M_W)'(CAM_M);
    assign mo = (ORG_Z_W+ORG_M_W)'(r_s4_zo) * (ORG_Z_W+ORG_M_W)'(ORG_M);

    always_ff @(posedge i_clk) begin
        r_s5_f1 <= mc[CAM_SH +: FADE_W];
        r_s5_f2 <= mo[ORG_SH +: FADE_W];
    end

    // Stage 6: combined fade
    logic [F12_W-1:0] r_s6_f12;
    logic [2*FADE_W-1:0] f12_full;

    assign f12_full = (2*FADE_W)'(r_s5_f1) * (2*FADE_W)'(r_s5_f2);

    always_ff @(posedge i_clk) begin
        r_s6_f12 <= f12_full[F12_W-1:0];
    end

    // Point light distance
    logic [ROOT_W-1:0] root;

    tlsa_isqrt_pipe u_isqrt (
        .i_clk  (i_clk),
        .i_rad  (r_s3_d2l),
        .o_root (root)
    );

    // Falloff operands: energy * r / (256 + r)
    logic [NUM_W-1:0] r_s11_num;
    logic [DEN_W-1:0] r_s11_den;

    always_ff @(posedge i_clk) begin
        r_s11_num <= NUM_W'(i_cfg.energy) * NUM_W'(root);
        r_s11_den <= DEN_W'(root) + DEN_W'(256);
    end

    logic [Q_W-1:0] quo;

    tlsa_div_pipe u_div (
        .i_clk (i_clk),
        .i_num (r_s11_num),
        .i_den (r_s11_den),
        .o_quo (quo)
    );

    // Hold facing flag and fade until the falloff is known
    logic             r_act_dly [ACT_DLY];
    logic [F12_W-1:0] r_f12_dly [F12_DLY];

    always_ff @(posedge i_clk) begin
        r_act_dly[0] <= r_s3_act;
        r_f12_dly[0] <= r_s6_f12;
        for (int i = 1; i < ACT_DLY; i++) begin
            r_act_dly[i] <= r_act_dly[i-1];
        end
        for (int i = 1; i < F12_DLY; i++) begin
            r_f12_dly[i] <= r_f12_dly[i-1];
        end
    end

    // Select energy and scale by the fades
    logic [ENG_W-1:0] energy;
    logic [P_W-1:0]   r_s16_p;

    assign energy = !r_act_dly[ACT_DLY-1] ? '0 :
                    (i_cfg.dir ? i_cfg.energy : quo);

    always_ff @(posedge i_clk) begin
        r_s16_p <= P_W'(energy) * P_W'(r_f12_dly[F12_DLY-1]);
    end

    // Final scaling and ceiling
    logic [P_W+ALPHA_GAIN_W-1:0] scaled;

    assign scaled = (P_W+ALPHA_GAIN_W)'(r_s16_p) * (P_W+ALPHA_GAIN_W)'(ALPHA_GAIN);

    always_ff @(posedge i_clk) begin
        o_alpha <= ALPHA_MAX - $signed(ALPHA_W'(scaled[ALPHA_SH +: K_W]));
    end

endmodule

FILE: rtl/core/triangle_light_shadow_alpha_unit.sv
// ----------------------------------------------------------------------------
// triangle_light_shadow_alpha_unit
// Per-vertex shadow alpha of a triangle from light energy and distance fades.
// ----------------------------------------------------------------------------
// One triangle is taken in every clock cycle while busy is low; its three
// alpha values come out together on o_valid at the end of the lane pipeline.
// The latency is set by the point light falloff: a square root resolving three
// digits per stage over seven stages, then a divider producing four quotient
// bits per stage over four stages. Results cannot be held off, so the block
// never stalls; busy is high only during reset and the cycle after it.
// Configuration writes take effect at once; the user must make them while no
// item is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module triangle_light_shadow_alpha_unit import tlsa_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]          i_cfg_data,
    input  t_coord                    i_p0_x,
    input  t_coord                    i_p0_y,
    input  t_coord                    i_p0_z,
    input  t_coord                    i_p1_x,
    input  t_coord                    i_p1_y,
    input  t_coord                    i_p1_z,
    input  t_coord                    i_p2_x,
    input  t_coord                    i_p2_y,
    input  t_coord                    i_p2_z,
    input  t_norm                     i_normal_x,
    input  t_norm                     i_normal_y,
    input  t_norm                     i_normal_z,
    output logic                      o_valid,
    output logic signed [ALPHA_W-1:0] o_alpha_0,
    output logic signed [ALPHA_W-1:0] o_alpha_1,
    output logic signed [ALPHA_W-1:0] o_alpha_2
);

    t_cfg             r_cfg;
    logic             r_rdy;
    logic [LATENCY-1:0] r_vld;
    logic             accept;

    assign busy   = ~r_rdy;
    assign accept = start & ~busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIR:    r_cfg.dir    <= i_cfg_data[0];
                CFG_LVEC:   r_cfg.lvec   <= i_cfg_data[VEC_W-1:0];
                CFG_RANGE:  r_cfg.rng    <= i_cfg_data[RNG_W-1:0];
                CFG_ENERGY: r_cfg.energy <= i_cfg_data[ENG_W-1:0];
                CFG_CAM:    r_cfg.cam    <= i_cfg_data[VEC_W-1:0];
                CFG_ORG:    r_cfg.org    <= i_cfg_data[VEC_W-1:0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    // Advance the valid bits alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
            r_vld <= '0;
        end else begin
            r_rdy <= 1'b1;
            r_vld <= {r_vld[LATENCY-2:0], accept};
        end
    end

    assign o_valid = r_vld[LATENCY-1];

    // One lane per vertex
    tlsa_vertex_lane u_lane0 (
        .i_clk (i_clk), .i_cfg (r_cfg),
        .i_px (i_p0_x), .i_py (i_p0_y), .i_pz (i_p0_z),
        .i_nx (i_normal_x), .i_ny (i_normal_y), .i_nz (i_normal_z),
        .o_alpha (o_alpha_0)
    );

    tlsa_vertex_lane u_lane1 (
        .i_clk (i_clk), .i_cfg (r_cfg),
        .i_px (i_p1_x), .i_py (i_p1_y), .i_pz (i_p1_z),
        .i_nx (i_normal_x), .i_ny (i_normal_y), .i_nz (i_normal_z),
        .o_alpha (o_alpha_1)
    );

    tlsa_vertex_lane u_lane2 (
        .i_clk (i_clk), .i_cfg (r_cfg),
        .i_px (i_p2_x), .i_py (i_p2_y), .i_pz (i_p2_z),
        .i_nx (i_normal_x), .i_ny (i_normal_y), .i_nz (i_normal_z),
        .o_alpha (o_alpha_2)
    );

    // Every strobe traces back to an accepted start
    a_vld_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LATENCY))
        else $error("result strobe without a matching accepted item");

    // Every accepted item yields a strobe
    a_accept_to_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("accepted item produced no result");

    // Reset flushes the pipeline
    a_rst_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && busy)
        else $error("strobe or ready right after reset");

    // Alpha never exceeds full opacity
    a_alpha_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_alpha_0 <= ALPHA_MAX) && (o_alpha_1 <= ALPHA_MAX)
                    && (o_alpha_2 <= ALPHA_MAX))
        else $error("alpha above 255");

endmodule

FILE: test/triangle_light_shadow_alpha_unit_tb.sv
// ----------------------------------------------------------------------------
// triangle_light_shadow_alpha_unit_tb
// Self-checking bench for the triangle shadow alpha unit. A queue of triangles
// feeds a clocked driver, while a clocked monitor checks each alpha triple
// against a bit-exact predictor. The predictor is computed at the accept edge
// from a local copy of the light and fade registers. The light is reconfigured
// between phases, only once the unit is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module triangle_light_shadow_alpha_unit_tb;
    import tlsa_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN       = LATENCY + 8;

    typedef struct {
        t_coord pc[9];
        t_norm  nv[3];
    } t_tri;

    typedef struct {
        logic signed [ALPHA_W-1:0] a[3];
    } t_alpha;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_W-1:0]          i_cfg_data;
    t_coord                    i_p0_x, i_p0_y, i_p0_z;
    t_coord                    i_p1_x, i_p1_y, i_p1_z;
    t_coord                    i_p2_x, i_p2_y, i_p2_z;
    t_norm                     i_normal_x, i_normal_y, i_normal_z;
    logic                      o_valid;
    logic signed [ALPHA_W-1:0] o_alpha_0, o_alpha_1, o_alpha_2;

    triangle_light_shadow_alpha_unit dut (.*);

    // Local copy of the light and fade registers
    logic              lt_dir;
    logic [VEC_W-1:0]  lt_vec;
    logic [RNG_W-1:0]  lt_rng;
    logic [ENG_W-1:0]  lt_energy;
    logic [VEC_W-1:0]  lt_cam;
    logic [VEC_W-1:0]  lt_org;

    t_tri   pending_tris[$];
    t_alpha expected_alphas[$];
    t_tri   cur_tri;
    int     gap_left;
    bit     no_idle;
    int     errors;
    int     checked;
    int     cycles;
    int     reg_writes;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void split_vec(input logic [VEC_W-1:0] v, output longint c[3]);
        c[0] = longint'($signed(v[19:0]));
        c[1] = longint'($signed(v[39:20]));
        c[2] = longint'($signed(v[59:40]));
    endfunction

    function automatic logic [VEC_W-1:0] pack_vec(input int x, input int y, input int z);
        logic [19:0] a, b, c;
        a = x[19:0];
        b = y[19:0];
        c = z[19:0];
        return {c, b, a};
    endfunction

    function automatic longint unsigned sq_dist(input longint a[3], input longint b[3]);
        longint unsigned s;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            s += longint'((a[i] - b[i]) * (a[i] - b[i]));
        end
        return s;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned fade_of(input longint unsigned d2,
                                                input longint unsigned t);
        if (d2 >= t) return 0;
        return ((t - d2) << 16) / t;
    endfunction

    // Alpha of one vertex under the current light and fade settings
    function automatic logic signed [ALPHA_W-1:0] vertex_alpha(input longint p[3],
                                                               input longint n[3]);
        longint          lv[3], cm[3], og[3];
        longint          dot;
        longint unsigned d2, e, r, f1, f2, pr, k;
        split_vec(lt_vec, lv);
        split_vec(lt_cam, cm);
        split_vec(lt_org, og);
        dot = 0;
        e = 0;
        if (lt_dir) begin
            for (int i = 0; i < 3; i++) dot += -lv[i] * n[i];
            e = (dot > 0) ? longint'(lt_energy) : 0;
        end else begin
            d2 = sq_dist(p, lv);
            if (d2 <= longint'(lt_rng) * longint'(lt_rng)) begin
                for (int i = 0; i < 3; i++) dot += (lv[i] - p[i]) * n[i];
                if (dot > 0) begin
                    r = int_sqrt(d2);
                    e = (longint'(lt_energy) * r) / (256 + r);
                end
            end
        end
        f1 = fade_of(sq_dist(cm, p), 64'd150994944);
        f2 = fade_of(sq_dist(og, p), 64'd1327104);
        pr = e * f1 * f2;
        k = ((765 * (pr >> 16)) + ((765 * (pr & 64'hFFFF)) >> 16)) >> 31;
        return ALPHA_W'(255 - longint'(k));
    endfunction

    function automatic t_alpha tri_alphas(input t_tri t);
        t_alpha r;
        longint p[3], n[3];
        for (int i = 0; i < 3; i++) n[i] = longint'(t.nv[i]);
        for (int v = 0; v < 3; v++) begin
            for (int i = 0; i < 3; i++) p[i] = longint'(t.pc[v * 3 + i]);
            r.a[v] = vertex_alpha(p, n);
        end
        return r;
    endfunction

    // Mirror register writes into the local copy
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIR:    lt_dir    <= i_cfg_data[0];
                CFG_LVEC:   lt_vec    <= i_cfg_data[VEC_W-1:0];
                CFG_RANGE:  lt_rng    <= i_cfg_data[RNG_W-1:0];
                CFG_ENERGY: lt_energy <= i_cfg_data[ENG_W-1:0];
                CFG_CAM:    lt_cam    <= i_cfg_data[VEC_W-1:0];
                CFG_ORG:    lt_org    <= i_cfg_data[VEC_W-1:0];
                default:    ;
            endcase
        end
    end

    // Driver: record accepted items, then present the next one or idle
    always @(posedge i_clk) begin : drive
        bit go;
        go = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) expected_alphas.push_back(tri_alphas(cur_tri));
            if (start && busy) begin
                go = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_tris.size() > 0) begin
                if (!no_idle && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(1, 8) - 1;
                end else begin
                    cur_tri = pending_tris.pop_front();
                    i_p0_x <= cur_tri.pc[0]; i_p0_y <= cur_tri.pc[1]; i_p0_z <= cur_tri.pc[2];
                    i_p1_x <= cur_tri.pc[3]; i_p1_y <= cur_tri.pc[4]; i_p1_z <= cur_tri.pc[5];
                    i_p2_x <= cur_tri.pc[6]; i_p2_y <= cur_tri.pc[7]; i_p2_z <= cur_tri.pc[8];
                    i_normal_x <= cur_tri.nv[0];
                    i_normal_y <= cur_tri.nv[1];
                    i_normal_z <= cur_tri.nv[2];
                    go = 1'b1;
                end
            end
            start <= go;
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin : watch
        t_alpha want;
        if (i_rst_n && o_valid) begin
            if (expected_alphas.size() == 0) begin
                $display("%0t: unexpected result %0d %0d %0d", $time,
                         o_alpha_0, o_alpha_1, o_alpha_2);
                errors++;
            end else begin
                want = expected_alphas.pop_front();
                checked++;
                if (o_alpha_0 !== want.a[0]) begin
                    $display("%0t: alpha_0 expected %0d actual %0d", $time, want.a[0], o_alpha_0);
                    errors++;
                end
                if (o_alpha_1 !== want.a[1]) begin
                    $display("%0t: alpha_1 expected %0d actual %0d", $time, want.a[1], o_alpha_1);
                    errors++;
                end
                if (o_alpha_2 !== want.a[2]) begin
                    $display("%0t: alpha_2 expected %0d actual %0d", $time, want.a[2], o_alpha_2);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_alphas.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Wait until nothing is queued or in flight, then let the pipe drain
    task automatic wait_idle();
        while (pending_tris.size() > 0 || start || gap_left > 0 || expected_alphas.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Write every register; spare indexes and high bits get junk
    task automatic set_light(input logic dir, input logic [VEC_W-1:0] lv,
                             input logic [RNG_W-1:0] rng, input logic [ENG_W-1:0] eng,
                             input logic [VEC_W-1:0] cam, input logic [VEC_W-1:0] org);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'({$urandom, $urandom});
        put_reg(CFG_DIR, {junk[CFG_W-1:1], dir});
        put_reg(CFG_LVEC, lv);
        put_reg(CFG_RANGE, {junk[CFG_W-1:RNG_W], rng});
        put_reg(CFG_ENERGY, {junk[CFG_W-1:ENG_W], eng});
        put_reg(CFG_CAM, cam);
        put_reg(CFG_ORG, org);
        put_reg(CFG_IDX_W'(6), junk);
        put_reg(CFG_IDX_W'(7), ~junk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Triangle around one point: the other vertices sit a little off it
    task automatic add_tri(input int x, input int y, input int z,
                           input int nx, input int ny, input int nz);
        t_tri t;
        t.pc[0] = x[19:0];      t.pc[1] = y[19:0];      t.pc[2] = z[19:0];
        t.pc[3] = 20'(x + 16);  t.pc[4] = y[19:0];      t.pc[5] = z[19:0];
        t.pc[6] = x[19:0];      t.pc[7] = 20'(y - 16);  t.pc[8] = z[19:0];
        t.nv[0] = nx[15:0];     t.nv[1] = ny[15:0];     t.nv[2] = nz[15:0];
        pending_tris.push_back(t);
    endtask

    function automatic int jitter(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Random triangle: mostly near the fade origin, some pure noise
    task automatic add_random_tri(input longint og[3]);
        t_tri t;
        int   span;
        span = ($urandom_range(0, 3) == 0) ? 3000 : 1200;
        for (int i = 0; i < 9; i++) begin
            if ($urandom_range(0, 6) == 0) t.pc[i] = 20'($urandom);
            else t.pc[i] = 20'(og[i % 3] + jitter(span));
        end
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(0, 7) == 0) t.nv[i] = 16'($urandom);
            else t.nv[i] = 16'(jitter(16384));
        end
        pending_tris.push_back(t);
    endtask

    initial begin : stimulus
        longint og[3];
        logic [RNG_W-1:0] rng;
        logic [ENG_W-1:0] eng;
        int cx, cy, cz;
        errors = 0; checked = 0; cycles = 0; reg_writes = 0;
        gap_left = 0; no_idle = 1'b0;
        i_rst_n <= 1'b0; start <= 1'b0;
        i_cfg_we <= 1'b0; i_cfg_idx <= '0; i_cfg_data <= '0;
        i_p0_x <= '0; i_p0_y <= '0; i_p0_z <= '0;
        i_p1_x <= '0; i_p1_y <= '0; i_p1_z <= '0;
        i_p2_x <= '0; i_p2_y <= '0; i_p2_z <= '0;
        i_normal_x <= '0; i_normal_y <= '0; i_normal_z <= '0;
        lt_dir = 0; lt_vec = '0; lt_rng = '0; lt_energy = '0; lt_cam = '0; lt_org = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Point light at the origin, range of three units, full energy
        set_light(1'b0, '0, 20'd768, 16'hFFFF, '0, '0);
        add_tri(0, 0, 0, 16384, 0, 0);              // vertex on the light
        add_tri(768, 0, 0, -16384, 0, 0);           // distance equals range
        add_tri(784, 0, 0, -16384, 0, 0);           // just beyond range
        add_tri(256, 0, 0, 0, 16384, 0);            // lit edge-on
        add_tri(256, 0, 0, 16384, 0, 0);            // facing away
        add_tri(-200, 100, 50, 32767, -32768, 0);   // normal beyond unit length
        add_tri(100, -100, 300, -32768, 32767, -32768);
        add_tri(524287, 524287, 524287, 16384, 16384, 16384);
        add_tri(-524288, -524288, -524288, -16384, -16384, -16384);
        wait_idle();

        // Directional light, full range and energy, near the fade origin
        set_light(1'b1, pack_vec(-256, 0, 0), 20'hFFFFF, 16'hFFFF, '0, '0);
        add_tri(0, 0, 0, 16384, 0, 0);              // strongest shadow
        add_tri(0, 0, 0, 0, 16384, 0);              // edge-on
        add_tri(0, 0, 0, -16384, 0, 0);
        add_tri(1152, 0, 0, 16384, 0, 0);           // at the origin fade radius
        add_tri(0, 12288, 0, 16384, 0, 0);          // at the camera fade radius
        add_tri(524287, -524288, 0, 32767, 0, 0);
        wait_idle();

        // Extreme register values
        set_light(1'b0, {VEC_W{1'b1}}, 20'hFFFFF, 16'hFFFF,
                  pack_vec(524287, -524288, 524287), pack_vec(-524288, 524287, -524288));
        add_tri(-524288, 524287, -524288, 16384, -16384, 16384);
        add_tri(-1, -1, -1, -16384, -16384, -16384);
        add_tri(524287, -524288, 524287, 1, 1, 1);
        wait_idle();

        // Random phases around random fade origins
        for (int ph = 0; ph < 9; ph++) begin
            cx = jitter(3000); cy = jitter(3000); cz = jitter(3000);
            case (ph % 3)
                0: rng = 20'($urandom_range(0, 4000));
                1: rng = 20'hFFFFF;
                default: rng = 20'($urandom);
            endcase
            eng = (ph == 4) ? 16'h0 : ((ph == 5) ? 16'hFFFF : 16'($urandom));
            set_light(ph[0],
                      ph[0] ? pack_vec(jitter(2000), jitter(2000), jitter(2000))
                            : pack_vec(cx + jitter(1500), cy + jitter(1500), cz + jitter(1500)),
                      rng, eng,
                      pack_vec(cx + jitter(5000), cy + jitter(5000), cz + jitter(5000)),
                      pack_vec(cx + jitter(300), cy + jitter(300), cz + jitter(300)));
            split_vec(lt_org, og);
            no_idle = (ph == 8);
            for (int n = 0; n < 150; n++) add_random_tri(og);
            wait_idle();
        end

        $display("Checked %0d triangles over %0d register writes,", checked, reg_writes);
        $display("point and directional lights, range and energy extremes.");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: triangle_light_shadow_alpha_unit.f
rtl/core/tlsa_pkg.sv
rtl/core/tlsa_isqrt_pipe.sv
rtl/core/tlsa_div_pipe.sv
rtl/core/tlsa_vertex_lane.sv
rtl/core/triangle_light_shadow_alpha_unit.sv
test/triangle_light_shadow_alpha_unit_tb.sv
